/* src/ppx_pkg.sv */
// Package for the plot point to pixel scaler: widths, constants, register
// indexes, the per-axis pipeline record and the pixel saturation helper.
// No dependencies.
package ppx_pkg;

  // Field widths.
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned DIFF_W    = 32;
  localparam int unsigned COL_W     = 7;
  localparam int unsigned ROW_W     = 8;

  // Plot geometry.
  localparam int unsigned PLOT_SPAN = 127;
  localparam int unsigned PIX_MAX   = 127;
  localparam int unsigned ROW_BASE  = 32;
  localparam int unsigned EDGE_OFF  = (PLOT_SPAN > PIX_MAX) ? PIX_MAX : PLOT_SPAN;

  // Quotient bits, product width and pipeline depth.
  localparam int unsigned QW        = $clog2(PLOT_SPAN + 1);
  localparam int unsigned PROD_W    = DIFF_W + QW;
  localparam int unsigned SAT_W     = (QW > COL_W) ? QW : COL_W;
  localparam int unsigned NSTG      = QW + 3;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 2'd3;

  localparam logic signed [VAL_W-1:0] MIN_X_RST = 32'sd0;
  localparam logic signed [VAL_W-1:0] MAX_X_RST = 32'sd1000;
  localparam logic signed [VAL_W-1:0] MIN_Y_RST = 32'sd0;
  localparam logic signed [VAL_W-1:0] MAX_Y_RST = 32'sd1000;

  // State of one axis as it moves down the pipeline.
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [DIFF_W-1:0] den;
    logic [QW-1:0]     quo;
    logic              in_rng;
    logic [COL_W-1:0]  edge_off;
  } ppx_axis_t;

  // Clamp a quotient to the last pixel of the plot.
  function automatic logic [COL_W-1:0] sat_pix(input logic [QW-1:0] q);
    logic [SAT_W-1:0] qe;
    qe = SAT_W'(q);
    return (qe > SAT_W'(PIX_MAX)) ? COL_W'(PIX_MAX) : COL_W'(qe);
  endfunction

endpackage

/* src/ppx_if.sv */
// Valid/ready channel interfaces for points in and pixels out.
// Depends on ppx_pkg.
interface ppx_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ppx_pkg::VAL_W-1:0]  x_value;
  logic signed [ppx_pkg::VAL_W-1:0]  y_value;
  logic                              last_point;

  modport source (output valid, output x_value, output y_value, output last_point,
                  input ready);
  modport sink   (input valid, input x_value, input y_value, input last_point,
                  output ready);
endinterface

interface ppx_out_if;
  logic                         valid;
  logic                         ready;
  logic [ppx_pkg::COL_W-1:0]    column;
  logic [ppx_pkg::ROW_W-1:0]    row;
  logic                         on_screen;
  logic                         last_out;

  modport source (output valid, output column, output row, output on_screen,
                  output last_out, input ready);
  modport sink   (input valid, input column, input row, input on_screen,
                  input last_out, output ready);
endinterface

/* src/ppx_axis_front.sv */
// Front end of one axis: bounds checks and differences, then the scale by
// the plot span. Two register stages. Depends on ppx_pkg.
module ppx_axis_front (
  input  logic                             clk_i,
  input  logic [1:0]                       en_i,
  input  logic signed [ppx_pkg::VAL_W-1:0] lo_i,
  input  logic signed [ppx_pkg::VAL_W-1:0] hi_i,
  input  logic signed [ppx_pkg::VAL_W-1:0] p_i,
  input  logic                             from_lo_i,
  output ppx_pkg::ppx_axis_t               axis_o
);
  import ppx_pkg::*;

  logic signed [VAL_W:0] lo_x, hi_x, p_x, span_x, num_x;
  ppx_axis_t             s0_d, s0_q, s1_d, s1_q;

  assign lo_x   = {lo_i[VAL_W-1], lo_i};
  assign hi_x   = {hi_i[VAL_W-1], hi_i};
  assign p_x    = {p_i[VAL_W-1], p_i};
  assign span_x = hi_x - lo_x;
  assign num_x  = from_lo_i ? (p_x - lo_x) : (hi_x - p_x);

  // Classify the point against the bounds and pick the clamp edge.
  always_comb begin
    s0_d          = '0;
    s0_d.rem      = PROD_W'(num_x[DIFF_W-1:0]);
    s0_d.den      = span_x[DIFF_W-1:0];
    priority if (hi_i <= lo_i) begin
      s0_d.edge_off = '0;
    end else if (p_i < lo_i) begin
      s0_d.edge_off = from_lo_i ? '0 : COL_W'(EDGE_OFF);
    end else if (p_i > hi_i) begin
      s0_d.edge_off = from_lo_i ? COL_W'(EDGE_OFF) : '0;
    end else begin
      s0_d.in_rng   = 1'b1;
    end
  end

  // Scale the numerator by the plot span.
  always_comb begin
    s1_d     = s0_q;
    s1_d.rem = PROD_W'(s0_q.rem[DIFF_W-1:0]) * PROD_W'(PLOT_SPAN);
  end

  // Stage 0 holds the differences, stage 1 the scaled numerator.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s0_q <= s0_d;
    end
    if (en_i[1]) begin
      s1_q <= s1_d;
    end
  end

  assign axis_o = s1_q;

endmodule

/* src/ppx_divider.sv */
// Restoring divider for one axis, one quotient bit per register stage.
// Depends on ppx_pkg.
module ppx_divider (
  input  logic                       clk_i,
  input  logic [ppx_pkg::QW-1:0]     en_i,
  input  ppx_pkg::ppx_axis_t         axis_i,
  output ppx_pkg::ppx_axis_t         axis_o
);
  import ppx_pkg::*;

  ppx_axis_t stg_in [QW];
  ppx_axis_t stg_d  [QW];
  ppx_axis_t stg_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int unsigned B = QW - 1 - k;
    logic [PROD_W-1:0] dsh;

    if (k == 0) begin : g_first
      assign stg_in[k] = axis_i;
    end else begin : g_next
      assign stg_in[k] = stg_q[k-1];
    end

    assign dsh = PROD_W'(stg_in[k].den) << B;

    // Subtract the shifted divisor when it fits and record the bit.
    always_comb begin
      stg_d[k] = stg_in[k];
      if (stg_in[k].rem >= dsh) begin
        stg_d[k].rem    = stg_in[k].rem - dsh;
        stg_d[k].quo[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign axis_o = stg_q[QW-1];

endmodule

/* src/plot_point_to_pixel_scaler.sv */
// Channel   | Dir | Payload                                 | Accepted when
// pt_i      | in  | x_value, y_value, last_point            | valid && ready
// px_o      | out | column, row, on_screen, last_out        | valid && ready
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i        | cfg_we_i high
//
// One point enters per cycle unless a stall backs up to the input. The pipeline
// has NSTG (10) register stages, the first loaded by the accepting edge and the
// last holding the result at the output. The depth is set by the two front stages,
// one divider stage per quotient bit and the output register. Every stage has
// its own valid bit and moves whenever it is empty or the stage after it moves,
// so bubbles close up and input keeps flowing while a result waits until the
// pipeline is full. Reset clears the valid bits and loads the default bounds.
// Depends on ppx_pkg, ppx_if, ppx_axis_front and ppx_divider.
module plot_point_to_pixel_scaler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ppx_in_if.sink                            pt_i,
  ppx_out_if.source                         px_o,
  input  logic                              cfg_we_i,
  input  logic [ppx_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ppx_pkg::VAL_W-1:0]         cfg_wdata_i
);
  import ppx_pkg::*;

  logic signed [VAL_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic [NSTG-1:0]         vld_q;
  logic [NSTG-1:0]         last_q;
  logic [NSTG-1:0]         en;
  ppx_axis_t               xf, yf, xd, yd;
  logic [COL_W-1:0]        col_d, roff_d;
  logic [COL_W-1:0]        col_q;
  logic [ROW_W-1:0]        row_q;
  logic                    on_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= MIN_X_RST;
      max_x_q <= MAX_X_RST;
      min_y_q <= MIN_Y_RST;
      max_y_q <= MAX_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_X: min_x_q <= cfg_wdata_i;
        CFG_MAX_X: max_x_q <= cfg_wdata_i;
        CFG_MIN_Y: min_y_q <= cfg_wdata_i;
        CFG_MAX_Y: max_y_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when its successor loads.
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || px_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign pt_i.ready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= pt_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // The last-point flag rides along with each transaction.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      last_q[0] <= pt_i.last_point;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  // Column measures from min_x, row offset from max_y.
  ppx_axis_front u_x_front (
    .clk_i     (clk_i),
    .en_i      (en[1:0]),
    .lo_i      (min_x_q),
    .hi_i      (max_x_q),
    .p_i       (pt_i.x_value),
    .from_lo_i (1'b1),
    .axis_o    (xf)
  );

  ppx_axis_front u_y_front (
    .clk_i     (clk_i),
    .en_i      (en[1:0]),
    .lo_i      (min_y_q),
    .hi_i      (max_y_q),
    .p_i       (pt_i.y_value),
    .from_lo_i (1'b0),
    .axis_o    (yf)
  );

  ppx_divider u_x_div (
    .clk_i  (clk_i),
    .en_i   (en[2 +: QW]),
    .axis_i (xf),
    .axis_o (xd)
  );

  ppx_divider u_y_div (
    .clk_i  (clk_i),
    .en_i   (en[2 +: QW]),
    .axis_i (yf),
    .axis_o (yd)
  );

  // Output stage: choose the quotient or the clamp edge.
  assign col_d  = xd.in_rng ? sat_pix(xd.quo) : xd.edge_off;
  assign roff_d = yd.in_rng ? sat_pix(yd.quo) : yd.edge_off;

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      col_q <= col_d;
      row_q <= ROW_W'(ROW_BASE) + ROW_W'(roff_d);
      on_q  <= xd.in_rng && yd.in_rng;
    end
  end

  assign px_o.valid     = vld_q[NSTG-1];
  assign px_o.column    = col_q;
  assign px_o.row       = row_q;
  assign px_o.on_screen = on_q;
  assign px_o.last_out  = last_q[NSTG-1];

  // An accepted transaction always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_i.valid && pt_i.ready |=> vld_q[0])
    else $error("accepted point did not enter the pipeline");

  // A stalled output with a full stage behind it must hold that stage.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTG-1] && !px_o.ready && vld_q[NSTG-2] |-> !en[NSTG-2])
    else $error("pipeline advanced into a stalled output");

  // Rows stay inside the plot area.
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    px_o.valid |-> (px_o.row >= ROW_W'(ROW_BASE)) &&
                   (px_o.row <= ROW_W'(ROW_BASE + PIX_MAX)))
    else $error("row outside the plot area");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for plot_point_to_pixel_scaler: streams points through the valid/ready
// channels and checks every pixel against a scaling model kept in this file.
// Depends on ppx_pkg, the ppx_in_if/ppx_out_if interfaces and the scaler RTL.
module tb_top;
  import ppx_pkg::*;

  localparam int     HOLD_CYCLES = 300;
  localparam int     STALL_LIMIT = 2000;
  localparam longint VAL_LO      = -64'sd2147483648;
  localparam longint VAL_HI      = 64'sd2147483647;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             on_screen;
    logic             last_out;
  } pixel_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [VAL_W-1:0]     cfg_wdata_i;

  ppx_in_if  pt_if ();
  ppx_out_if px_if ();

  plot_point_to_pixel_scaler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_i        (pt_if),
    .px_o        (px_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Local copy of the plot bounds, updated as each register write lands.
  logic signed [VAL_W-1:0] lim_min_x, lim_max_x, lim_min_y, lim_max_y;

  pixel_t pixels_due[$];
  int     send_idle_pct;
  int     stall_pct;
  int     mismatch_count;
  int     quiet_cycles;
  int     hold_cnt;
  logic   hold_on;

  always #4 clk_i = ~clk_i;

  // Offset of a point along one axis, measured from the low bound (columns)
  // or from the high bound (rows). Out-of-range points clamp to an edge.
  function automatic logic [COL_W-1:0] axis_offset(input longint lo, input longint hi,
                                                   input longint p, input bit from_lo,
                                                   output bit in_rng);
    longint unsigned offs;
    longint unsigned span;
    longint unsigned quo;
    in_rng = 1'b0;
    if (hi <= lo) return '0;
    if (p < lo) return from_lo ? COL_W'(0) : COL_W'(EDGE_OFF);
    if (p > hi) return from_lo ? COL_W'(EDGE_OFF) : COL_W'(0);
    in_rng = 1'b1;
    span = hi - lo;
    offs = from_lo ? p - lo : hi - p;
    quo  = (longint'(PLOT_SPAN) * offs) / span;
    return (quo > PIX_MAX) ? COL_W'(PIX_MAX) : COL_W'(quo);
  endfunction

  // Expected pixel for one point under the current bounds.
  function automatic pixel_t predict_pixel(input logic signed [VAL_W-1:0] x,
                                           input logic signed [VAL_W-1:0] y,
                                           input logic is_last);
    pixel_t px;
    bit     in_x;
    bit     in_y;
    logic [COL_W-1:0] row_off;
    px.column    = axis_offset(lim_min_x, lim_max_x, x, 1'b1, in_x);
    row_off      = axis_offset(lim_min_y, lim_max_y, y, 1'b0, in_y);
    px.row       = ROW_W'(ROW_BASE + row_off);
    px.on_screen = in_x && in_y;
    px.last_out  = is_last;
    return px;
  endfunction

  // Random bounds: full range, empty or reversed, narrow, medium or wide spans.
  function automatic void pick_range(output longint lo, output longint hi);
    longint span;
    lo = $signed($urandom);
    span = 0;
    case ($urandom_range(9))
      0: begin
        lo = VAL_LO;
        hi = VAL_HI;
      end
      1: begin
        hi = lo - $urandom_range(2);
        if (hi < VAL_LO) hi = VAL_LO;
      end
      2, 3, 4: span = $urandom_range(300, 1);
      5, 6, 7: span = $urandom_range(1 << 20, 301);
      default: span = $urandom_range(32'hFFFF_FFFF, 1);
    endcase
    if (span != 0) begin
      hi = lo + span;
      if (hi > VAL_HI) begin
        hi = VAL_HI;
        lo = hi - span;
      end
    end
  endfunction

  // Random coordinate: mostly near the bounds, sometimes exactly on them,
  // sometimes anywhere in the 32-bit range.
  function automatic logic signed [VAL_W-1:0] pick_coord(input longint lo, input longint hi);
    longint          a;
    longint          b;
    longint          margin;
    longint unsigned width;
    longint unsigned r;
    int              pick;
    pick = $urandom_range(9);
    if (pick < 3) return $urandom;
    if (pick == 3) return VAL_W'(lo);
    if (pick == 4) return VAL_W'(hi);
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    margin = (b - a) / 8 + 2;
    a = (a - margin < VAL_LO) ? VAL_LO : a - margin;
    b = (b + margin > VAL_HI) ? VAL_HI : b + margin;
    width = b - a + 1;
    r = {$urandom, $urandom};
    return VAL_W'(a + longint'(r % width));
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Offer one point, with random idle cycles first, and record its pixel
  // once the transaction is accepted.
  task automatic send_point(input logic signed [VAL_W-1:0] x,
                            input logic signed [VAL_W-1:0] y, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      pt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pt_if.valid      <= 1'b1;
    pt_if.x_value    <= x;
    pt_if.y_value    <= y;
    pt_if.last_point <= is_last;
    do @(posedge clk_i); while (!pt_if.ready);
    pixels_due.push_back(predict_pixel(x, y, is_last));
  endtask

  // Stop offering, wait for every outstanding pixel, then let the pipe empty.
  task automatic wait_drain();
    pt_if.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (NSTG + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_MIN_X: lim_min_x = val;
      CFG_MAX_X: lim_max_x = val;
      CFG_MIN_Y: lim_min_y = val;
      CFG_MAX_Y: lim_max_y = val;
      default: ;
    endcase
  endtask

  // Writes all four bounds on back-to-back edges; the block must be idle.
  task automatic set_bounds(input logic signed [VAL_W-1:0] lo_x,
                            input logic signed [VAL_W-1:0] hi_x,
                            input logic signed [VAL_W-1:0] lo_y,
                            input logic signed [VAL_W-1:0] hi_y);
    write_reg(CFG_MIN_X, lo_x);
    write_reg(CFG_MAX_X, hi_x);
    write_reg(CFG_MIN_Y, lo_y);
    write_reg(CFG_MAX_Y, hi_y);
    cfg_we_i <= 1'b0;
  endtask

  // Bounds straight out of reset: corners, center and each side outside.
  task automatic test_reset_bounds();
    send_point(0, 0, 1'b0);
    send_point(1000, 1000, 1'b1);
    send_point(500, 500, 1'b0);
    send_point(999, 1, 1'b0);
    send_point(-1, 500, 1'b0);
    send_point(1001, 500, 1'b1);
    send_point(500, 1001, 1'b0);
    send_point(500, -1, 1'b0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
  endtask

  // Full 32-bit bounds on both axes, which need the widest intermediates.
  task automatic test_wide_bounds();
    wait_drain();
    set_bounds(VAL_W'(VAL_LO), VAL_W'(VAL_HI), VAL_W'(VAL_LO), VAL_W'(VAL_HI));
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(-1, 1, 1'b1);
  endtask

  // Bounds one unit apart, with negative y.
  task automatic test_unit_bounds();
    wait_drain();
    set_bounds(5, 6, -7, -6);
    send_point(5, -7, 1'b0);
    send_point(6, -6, 1'b1);
    send_point(7, -8, 1'b0);
  endtask

  // Empty and reversed bounds on each axis in turn.
  task automatic test_degenerate_bounds();
    wait_drain();
    set_bounds(100, 100, 50, -50);
    send_point(100, 0, 1'b0);
    send_point(100, 50, 1'b1);
    wait_drain();
    set_bounds(20, -20, 7, 7);
    send_point(0, 7, 1'b0);
    send_point(-20, 8, 1'b1);
  endtask

  // Random points under random bounds, which change every 25 points.
  task automatic run_batches(input int idle, input int stall, input int count);
    longint xl;
    longint xh;
    longint yl;
    longint yh;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        wait_drain();
        pick_range(xl, xh);
        pick_range(yl, yh);
        set_bounds(VAL_W'(xl), VAL_W'(xh), VAL_W'(yl), VAL_W'(yh));
      end
      send_point(pick_coord(xl, xh), pick_coord(yl, yh), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_random_traffic();
    run_batches(0, 0, 100);
    run_batches(87, 0, 100);
    run_batches(0, 87, 100);
    run_batches(32, 32, 125);
  endtask

  // Receiver holds off while points keep coming, so the pipeline fills and
  // stalls its input; afterward the sender waits for every pixel.
  task automatic test_backpressure();
    longint xl;
    longint xh;
    longint yl;
    longint yh;
    wait_drain();
    send_idle_pct = 0;
    stall_pct     = 0;
    pick_range(xl, xh);
    pick_range(yl, yh);
    set_bounds(VAL_W'(xl), VAL_W'(xh), VAL_W'(yl), VAL_W'(yh));
    hold_on <= 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_point(pick_coord(xl, xh), pick_coord(yl, yh), 1'($urandom_range(1)));
    end
    wait_drain();
    hold_on <= 1'b0;
  endtask

  // Receiver ready, with random stalls and an optional long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      px_if.ready <= 1'b0;
      hold_cnt    <= 0;
    end else begin
      hold_cnt <= hold_on ? hold_cnt + 1 : 0;
      if (hold_on && hold_cnt < HOLD_CYCLES) px_if.ready <= 1'b0;
      else px_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each pixel transaction with the oldest expected pixel.
  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && px_if.valid && px_if.ready) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel transaction: column %0d, row %0d",
               px_if.column, px_if.row);
        mismatch_count++;
      end else begin
        want = pixels_due.pop_front();
        check_field("column", want.column, px_if.column);
        check_field("row", want.row, px_if.row);
        check_field("on_screen", want.on_screen, px_if.on_screen);
        check_field("last_out", want.last_out, px_if.last_out);
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (pt_if.valid && pt_if.ready) || (px_if.valid && px_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    pt_if.valid      = 1'b0;
    pt_if.x_value    = '0;
    pt_if.y_value    = '0;
    pt_if.last_point = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_MIN_X;
    cfg_wdata_i      = '0;
    hold_on          = 1'b0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    mismatch_count   = 0;
    lim_min_x        = MIN_X_RST;
    lim_max_x        = MAX_X_RST;
    lim_min_y        = MIN_Y_RST;
    lim_max_y        = MAX_Y_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_bounds();
    test_wide_bounds();
    test_unit_bounds();
    test_degenerate_bounds();
    test_random_traffic();
    test_backpressure();
    wait_drain();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
